// File: hw/rtl/ppc_pkg.sv
package ppc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int PROD_W       = 2 * DIFF_W;

    localparam logic [1:0] CLS_VERTEX  = 2'd0;
    localparam logic [1:0] CLS_EDGE    = 2'd1;
    localparam logic [1:0] CLS_INSIDE  = 2'd2;
    localparam logic [1:0] CLS_OUTSIDE = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FIRST = 7'b0000010,
        S_EDGE  = 7'b0000100,
        S_MUL1  = 7'b0001000,
        S_MUL2  = 7'b0010000,
        S_CMP   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic                         wr_en;
        logic [ADDR_W-1:0]            wr_addr;
        logic signed [COORD_BITS-1:0] wr_x;
        logic signed [COORD_BITS-1:0] wr_y;
        logic                         rd_en;
        logic [ADDR_W-1:0]            rd_addr;
    } t_mem_req;

endpackage

// File: hw/rtl/ppc_vtx_mem.sv
module ppc_vtx_mem (
    input  logic                                   i_clk,
    input  ppc_pkg::t_mem_req                      i_req,
    output logic signed [ppc_pkg::COORD_BITS-1:0]  o_rd_x,
    output logic signed [ppc_pkg::COORD_BITS-1:0]  o_rd_y
);

    logic [2*ppc_pkg::COORD_BITS-1:0] r_mem [ppc_pkg::MAX_VERTICES];
    logic [2*ppc_pkg::COORD_BITS-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= {i_req.wr_x, i_req.wr_y};
        end
        if (i_req.rd_en) begin
            r_rd <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_x = r_rd[2*ppc_pkg::COORD_BITS-1:ppc_pkg::COORD_BITS];
    assign o_rd_y = r_rd[ppc_pkg::COORD_BITS-1:0];

endmodule

// File: hw/rtl/polygon_point_classifier.sv
// Write request: stored straight from idle, no result. n = vertex_count, at most 64.
// Query: a contact pass (one vertex read per edge), then a crossing pass in which each
// straddling edge also goes through S_MUL1, S_MUL2 and S_CMP (two 17x17 multiplies, compare).
// o_valid rises after the crossing pass (sooner on a contact; when n < 3 the query goes
// straight to S_DONE); input stalls until the result register takes it. One query in flight.
// Reset (synchronous, active low) clears vertex_count and control; table undefined.
module polygon_point_classifier (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [ppc_pkg::CNT_W-1:0]             i_cfg_wr_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_op,
    input  logic [ppc_pkg::ADDR_W-1:0]            i_vertex_index,
    input  logic signed [ppc_pkg::COORD_BITS-1:0] i_x_coord,
    input  logic signed [ppc_pkg::COORD_BITS-1:0] i_y_coord,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [1:0]                            o_point_class,
    output logic [ppc_pkg::ADDR_W-1:0]            o_edge_index
);

    localparam int CW = ppc_pkg::COORD_BITS;
    localparam int DW = ppc_pkg::DIFF_W;
    localparam int PW = ppc_pkg::PROD_W;
    localparam int KW = ppc_pkg::CNT_W;
    localparam int AW = ppc_pkg::ADDR_W;
    localparam logic [KW-1:0] MAXN = KW'(ppc_pkg::MAX_VERTICES);

    ppc_pkg::t_state   r_state, n_state;
    ppc_pkg::t_mem_req w_req;
    logic [KW-1:0]     r_cnt;
    logic [KW-1:0]     r_k, n_k;
    logic              r_pass, n_pass;
    logic              r_par, n_par;
    logic signed [CW-1:0] r_qx, r_qy, r_px, r_py, n_px, n_py;
    logic [1:0]        r_cls, n_cls;
    logic [AW-1:0]     r_edge, n_edge;
    logic              r_ovalid, n_ovalid;
    logic [1:0]        r_ocls, n_ocls;
    logic [AW-1:0]     r_oedge, n_oedge;
    logic [DW-1:0]     r_mdx, r_mry, r_md, r_m;
    logic              r_neg, r_force, r_fval;
    logic [PW-1:0]     r_p1, r_p2;
    logic signed [CW-1:0] w_cx, w_cy;
    logic [KW-1:0]     w_n, w_k1;
    logic signed [DW-1:0] w_dx, w_ry, w_dy, w_t;
    logic signed [DW:0]   w_m;
    logic              w_hit, w_atv, w_strad, w_neg, w_cross, w_adv;

    ppc_vtx_mem u_mem (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_rd_x (w_cx),
        .o_rd_y (w_cy)
    );

    function automatic logic f_between(logic signed [CW-1:0] v, logic signed [CW-1:0] a,
                                       logic signed [CW-1:0] b);
        return (a <= b) ? (a <= v && v <= b) : (b <= v && v <= a);
    endfunction

    function automatic logic [DW-1:0] f_mag(logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    assign w_n  = (r_cnt > MAXN) ? MAXN : r_cnt;
    assign w_k1 = r_k + KW'(1);
    assign w_dx = DW'(w_cx) - DW'(r_px);
    assign w_dy = DW'(w_cy) - DW'(r_py);
    assign w_ry = DW'(r_qy) - DW'(r_py);
    assign w_t  = DW'(r_qx) - DW'(r_px);
    assign w_neg = ((w_dx < 0) != (w_ry < 0)) != (w_dy < 0);
    assign w_m  = w_neg ? ((DW+1)'(1) - (DW+1)'(w_t)) : (DW+1)'(w_t);
    assign w_strad = (r_py > r_qy) != (w_cy > r_qy);
    assign w_hit = (r_py == w_cy) ? (r_qy == r_py && f_between(r_qx, r_px, w_cx)) :
                   (r_px == w_cx) ? (r_qx == r_px && f_between(r_qy, r_py, w_cy)) : 1'b0;
    assign w_atv = (r_qx == r_px && r_qy == r_py) || (r_qx == w_cx && r_qy == w_cy);
    assign w_cross = r_force ? r_fval : (r_neg ? (r_p2 > r_p1) : (r_p2 <= r_p1));

    assign o_stall       = (r_state != ppc_pkg::S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_point_class = r_ocls;
    assign o_edge_index  = r_oedge;

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_pass   = r_pass;
        n_par    = r_par;
        n_px     = r_px;
        n_py     = r_py;
        n_cls    = r_cls;
        n_edge   = r_edge;
        n_ovalid = r_ovalid && i_stall;
        n_ocls   = r_ocls;
        n_oedge  = r_oedge;
        w_adv    = 1'b0;
        w_req.wr_en   = 1'b0;
        w_req.wr_addr = i_vertex_index;
        w_req.wr_x    = i_x_coord;
        w_req.wr_y    = i_y_coord;
        w_req.rd_en   = 1'b0;
        w_req.rd_addr = '0;
        unique case (r_state)
            ppc_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_op == ppc_pkg::OP_WRITE) begin
                        w_req.wr_en = 1'b1;
                    end else begin
                        n_cls  = ppc_pkg::CLS_OUTSIDE;
                        n_edge = '0;
                        n_pass = 1'b0;
                        n_par  = 1'b0;
                        if (w_n < KW'(3)) begin
                            n_state = ppc_pkg::S_DONE;
                        end else begin
                            w_req.rd_en = 1'b1;
                            n_state = ppc_pkg::S_FIRST;
                        end
                    end
                end
            end
            ppc_pkg::S_FIRST: begin
                n_px = w_cx;
                n_py = w_cy;
                n_k  = KW'(1);
                w_req.rd_en   = 1'b1;
                w_req.rd_addr = AW'(1);
                n_state = ppc_pkg::S_EDGE;
            end
            ppc_pkg::S_EDGE: begin
                if (!r_pass) begin
                    if (w_hit) begin
                        n_cls   = w_atv ? ppc_pkg::CLS_VERTEX : ppc_pkg::CLS_EDGE;
                        n_edge  = AW'(r_k - KW'(1));
                        n_state = ppc_pkg::S_DONE;
                    end else begin
                        w_adv = 1'b1;
                    end
                end else if (w_strad) begin
                    n_state = ppc_pkg::S_MUL1;
                end else begin
                    w_adv = 1'b1;
                end
            end
            ppc_pkg::S_MUL1: n_state = ppc_pkg::S_MUL2;
            ppc_pkg::S_MUL2: n_state = ppc_pkg::S_CMP;
            ppc_pkg::S_CMP: begin
                if (w_cross) begin
                    n_par = !r_par;
                end
                w_adv = 1'b1;
            end
            ppc_pkg::S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_ocls   = r_cls;
                    n_oedge  = r_edge;
                    n_state  = ppc_pkg::S_IDLE;
                end
            end
            default: n_state = ppc_pkg::S_IDLE;
        endcase
        if (w_adv) begin
            if (r_k == w_n) begin
                if (!r_pass) begin
                    n_pass = 1'b1;
                    w_req.rd_en   = 1'b1;
                    w_req.rd_addr = '0;
                    n_state = ppc_pkg::S_FIRST;
                end else begin
                    n_cls   = n_par ? ppc_pkg::CLS_INSIDE : ppc_pkg::CLS_OUTSIDE;
                    n_edge  = '0;
                    n_state = ppc_pkg::S_DONE;
                end
            end else begin
                n_k  = w_k1;
                n_px = w_cx;
                n_py = w_cy;
                w_req.rd_en   = 1'b1;
                w_req.rd_addr = (w_k1 == w_n) ? '0 : AW'(w_k1);
                n_state = ppc_pkg::S_EDGE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ppc_pkg::S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_k      <= '0;
            r_pass   <= 1'b0;
            r_par    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_k      <= n_k;
            r_pass   <= n_pass;
            r_par    <= n_par;
            if (i_cfg_wr_en) begin
                r_cnt <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_px    <= n_px;
        r_py    <= n_py;
        r_cls   <= n_cls;
        r_edge  <= n_edge;
        r_ocls  <= n_ocls;
        r_oedge <= n_oedge;
        if (r_state == ppc_pkg::S_IDLE && i_valid) begin
            r_qx <= i_x_coord;
            r_qy <= i_y_coord;
        end
        if (r_state == ppc_pkg::S_EDGE) begin
            r_mdx   <= f_mag(w_dx);
            r_mry   <= f_mag(w_ry);
            r_md    <= f_mag(w_dy);
            r_m     <= DW'(w_m);
            r_neg   <= w_neg;
            r_force <= w_neg ? (w_t > 0) : (w_t < 0);
            r_fval  <= !w_neg;
        end
        if (r_state == ppc_pkg::S_MUL1) begin
            r_p1 <= r_mdx * r_mry;
        end
        if (r_state == ppc_pkg::S_MUL2) begin
            r_p2 <= r_m * r_md;
        end
    end

endmodule
